// ===== rtl/ldhs_pkg.sv =====
// ----------------------------------------------------------------------------
// ldhs_pkg
// Shared widths, register indexes, command codes and reset values for the
// LOOK / C-LOOK disk head scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ldhs_pkg;

  localparam int unsigned CylW          = 6;
  localparam int unsigned CntW          = 7;
  localparam int unsigned CylindersDef  = 64;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  typedef logic [CylW-1:0]     cyl_t;
  typedef logic [CntW-1:0]     cnt_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  localparam cfg_idx_t RegMode      = 2'd0;
  localparam cfg_idx_t RegHeadStart = 2'd1;
  localparam cfg_idx_t RegStartUp   = 2'd2;

  localparam logic CmdAdd  = 1'b0;
  localparam logic CmdTick = 1'b1;

  localparam logic ModeLook  = 1'b0;
  localparam logic ModeCLook = 1'b1;

  localparam logic ModeRst      = ModeCLook;
  localparam cyl_t HeadStartRst = 6'd10;
  localparam logic StartUpRst   = 1'b1;
  localparam cyl_t LowestRst    = 6'd63;
  localparam cyl_t HighestRst   = 6'd0;

endpackage

`default_nettype wire

// ===== rtl/look_disk_head_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// look_disk_head_scheduler_core
// Disk head scheduler with LOOK and C-LOOK sweep modes.
//
// Usage: an item (cmd_i, cylinder_i) is taken when start_i is high and busy_o
// is low. cmd_i = add marks a cylinder as pending; cmd_i = tick, while any
// cylinder is pending, serves the cylinder under the head if pending, applies
// the end-of-sweep rule and moves the head one cylinder (C-LOOK instead jumps
// to the other end at the end of a sweep). Every item gives exactly one
// result, shown for one cycle with done_o high; the receiver cannot stall, so
// results are simply strobed out.
// Flow: the item is latched and its pending bit is read from the pending
// memory (one read port, one write port) into rd_q; in StExec it is modified
// and written back and the result registers and done_o are set. A new item is
// taken only after that; busy_o is high while an item is in its write-back state.
// Reset: a clearing pass writes each of the min(CYLINDERS, 64) entries of the
// pending memory, one per cycle; busy_o stays high meanwhile.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at
// once: head_start reloads the head, start_up reloads the direction.
// ----------------------------------------------------------------------------
`default_nettype none

module look_disk_head_scheduler_core #(
  parameter int unsigned CYLINDERS = ldhs_pkg::CylindersDef
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire ldhs_pkg::cfg_idx_t   cfg_idx_i,
  input  wire ldhs_pkg::cfg_data_t  cfg_data_i,
  input  wire                       start_i,
  output logic                      busy_o,
  input  wire                       cmd_i,
  input  wire ldhs_pkg::cyl_t       cylinder_i,
  output logic                      done_o,
  output ldhs_pkg::cyl_t            head_pos_o,
  output logic                      served_o,
  output ldhs_pkg::cyl_t            next_head_o,
  output logic                      moving_up_o,
  output ldhs_pkg::cnt_t            pending_left_o,
  output logic                      all_done_o
);
  import ldhs_pkg::*;

  localparam int unsigned Depth = (CYLINDERS > 64) ? 64 : CYLINDERS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam cyl_t        Top   = cyl_t'(Depth - 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam cyl_t HeadRst = (HeadStartRst > Top) ? Top : HeadStartRst;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StExec
  } state_e;

  state_e state_q;

  // pending memory, one bit per cylinder
  logic pend_mem [Depth];
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic             mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic             rd_q;

  logic mode_q;
  cyl_t head_q, head_d;
  logic dir_q, dir_d;
  cyl_t lo_q, lo_d;
  cyl_t hi_q, hi_d;
  cnt_t total_q, total_d;

  logic             cmd_q;
  cyl_t             cyl_q;
  logic [AddrW-1:0] clr_q;

  logic accept;
  logic add_ok;
  logic srv;
  logic jumped;
  cyl_t head_clamped;

  assign accept = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);
  assign mem_raddr = (cmd_i == CmdAdd) ? cylinder_i[AddrW-1:0] : head_q[AddrW-1:0];
  assign head_clamped = (cfg_data_i > Top) ? Top : cfg_data_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pend_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= pend_mem[mem_raddr];
  end

  // read-modify-write of one item, and the clearing write of the reset pass
  always_comb begin
    head_d    = head_q;
    dir_d     = dir_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    total_d   = total_q;
    srv       = 1'b0;
    jumped    = 1'b0;
    add_ok    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 1'b0;

    if (state_q == StClear) begin
      mem_we = 1'b1;
    end else if (state_q == StExec) begin
      if (cmd_q == CmdAdd) begin
        add_ok = (cyl_q <= Top) && !rd_q;
        if (add_ok) begin
          mem_we    = 1'b1;
          mem_waddr = cyl_q[AddrW-1:0];
          mem_wdata = 1'b1;
          total_d   = total_q + cnt_t'(1);
          if (cyl_q < lo_q) lo_d = cyl_q;
          if (cyl_q > hi_q) hi_d = cyl_q;
        end
      end else if (total_q != '0) begin
        if (rd_q) begin
          mem_we    = 1'b1;
          mem_waddr = head_q[AddrW-1:0];
          srv       = 1'b1;
          total_d   = total_q - cnt_t'(1);
        end
        if (mode_q == ModeLook) begin
          if (dir_q && head_q >= hi_q) dir_d = 1'b0;
          else if (!dir_q && head_q <= lo_q) dir_d = 1'b1;
        end else begin
          if (dir_q && head_q >= hi_q) begin
            head_d = lo_q;
            jumped = 1'b1;
          end else if (!dir_q && head_q <= lo_q) begin
            head_d = hi_q;
            jumped = 1'b1;
          end
        end
        if (!jumped) begin
          if (dir_d) begin
            if (head_q < Top) head_d = head_q + cyl_t'(1);
          end else begin
            if (head_q != '0) head_d = head_q - cyl_t'(1);
          end
        end
        if (head_d > Top) head_d = Top;
        // batch finished: open a new one
        if (total_d == '0) begin
          lo_d = LowestRst;
          hi_d = HighestRst;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StClear;
      clr_q          <= '0;
      mode_q         <= ModeRst;
      head_q         <= HeadRst;
      dir_q          <= StartUpRst;
      lo_q           <= LowestRst;
      hi_q           <= HighestRst;
      total_q        <= '0;
      cmd_q          <= CmdAdd;
      cyl_q          <= '0;
      done_o         <= 1'b0;
      head_pos_o     <= '0;
      served_o       <= 1'b0;
      next_head_o    <= '0;
      moving_up_o    <= 1'b0;
      pending_left_o <= '0;
      all_done_o     <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + AddrW'(1);
          if (clr_q == LastAddr) state_q <= StIdle;
        end
        StIdle: begin
          if (accept) begin
            cmd_q   <= cmd_i;
            cyl_q   <= cylinder_i;
            state_q <= StExec;
          end
        end
        StExec: begin
          head_q         <= head_d;
          dir_q          <= dir_d;
          lo_q           <= lo_d;
          hi_q           <= hi_d;
          total_q        <= total_d;
          done_o         <= 1'b1;
          head_pos_o     <= head_q;
          served_o       <= srv;
          next_head_o    <= head_d;
          moving_up_o    <= dir_d;
          pending_left_o <= total_d;
          all_done_o     <= (total_d == '0);
          state_q        <= StIdle;
        end
        default: state_q <= StIdle;
      endcase

      // the user must issue writes only while no item is in flight; the block does not enforce it
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegMode:      mode_q <= cfg_data_i[0];
          RegHeadStart: head_q <= head_clamped;
          RegStartUp:   dir_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire
